@@ hw/rtl/mmeu_pkg.sv @@
// Shared constants and the speed scaling function for the encoder unwrap block.
`default_nettype none
package mmeu_pkg;

  localparam logic [10:0] BASE_ID = 11'h201;

  localparam int ANGLE_W = 13;
  localparam int STEP_W  = 14;
  localparam int SPEED_W = 16;
  localparam int TOTAL_W = 48;
  localparam int SCALE_W = 11;

  localparam logic signed [14:0] TICKS_PER_REV = 15'sd8192;
  localparam logic signed [14:0] HALF_REV      = 15'sd4096;
  localparam logic signed [13:0] QUARTER_REV   = 14'sd2048;
  localparam logic signed [15:0] SPEED_GATE    = 16'sd200;

  // x / 60 == (x * 34953) >> 21 for 0 <= x <= 32768
  localparam logic [15:0] SPEED_RECIP = 16'd34953;
  localparam int          RECIP_SHIFT = 21;

  // Signed speed divided by 60, truncated toward zero.
  function automatic logic signed [SCALE_W-1:0] speed_div60(
    input logic signed [SPEED_W-1:0] s
  );
    logic [SPEED_W-1:0]   mag;
    logic [2*SPEED_W-1:0] prod;
    logic [SCALE_W-1:0]   q;
    mag  = s[SPEED_W-1] ? (~s + 16'd1) : s;
    prod = mag * SPEED_RECIP;
    q    = prod[RECIP_SHIFT +: SCALE_W];
    return s[SPEED_W-1] ? $signed(~q + 11'd1) : $signed(q);
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mmeu_step.sv @@
// Angle step computation: half-turn wrap plus the direction noise correction.
`default_nettype none
module mmeu_step (
  input  wire logic        [mmeu_pkg::ANGLE_W-1:0] angle,
  input  wire logic        [mmeu_pkg::ANGLE_W-1:0] prev_angle,
  input  wire logic signed [mmeu_pkg::STEP_W-1:0]  prev_step,
  input  wire logic signed [mmeu_pkg::SPEED_W-1:0] speed,
  output logic signed      [mmeu_pkg::STEP_W-1:0]  step
);

  logic signed [14:0] diff;
  logic signed [14:0] wrapped;
  logic signed [14:0] fixed;
  logic               fwd_gate;
  logic               rev_gate;

  always_comb begin
    diff = $signed({2'b00, angle}) - $signed({2'b00, prev_angle});
    if (diff > mmeu_pkg::HALF_REV) begin
      wrapped = diff - mmeu_pkg::TICKS_PER_REV;
    end else if (diff < -mmeu_pkg::HALF_REV) begin
      wrapped = diff + mmeu_pkg::TICKS_PER_REV;
    end else begin
      wrapped = diff;
    end

    fwd_gate = (prev_step > mmeu_pkg::QUARTER_REV) && (speed > mmeu_pkg::SPEED_GATE);
    rev_gate = (prev_step < -mmeu_pkg::QUARTER_REV) && (speed < -mmeu_pkg::SPEED_GATE);

    fixed = wrapped;
    if (fwd_gate) begin
      if (wrapped < 15'sd0) begin
        fixed = wrapped + mmeu_pkg::TICKS_PER_REV;
      end
    end else if (rev_gate) begin
      if (wrapped > 15'sd0) begin
        fixed = wrapped - mmeu_pkg::TICKS_PER_REV;
      end
    end
    // result always lies in -8191..8191
    step = fixed[mmeu_pkg::STEP_W-1:0];
  end

endmodule
`default_nettype wire

@@ hw/rtl/multi_motor_encoder_unwrap.sv @@
// Top level: multi-turn encoder angle unwrap for a bank of motors.
// Path: input register, then result register, from input accept to result valid.
// Throughput: 1 item per cycle unless out_ready stalls the output; per-motor
//   state is read and written in the cycle an item leaves the input register,
//   so back-to-back frames for the same motor see the updated state.
// Reset (rst, synchronous): clears both valid flags and all per-motor state.
`default_nettype none
module multi_motor_encoder_unwrap #(
  parameter int MOTORS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] frame_id,
  input  wire logic [10:0] wanted_id,
  input  wire logic [12:0] encoder_angle,
  input  wire logic signed [15:0] rotor_speed,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic [1:0]       motor_num,
  output logic signed [47:0] total_ticks,
  output logic signed [10:0] speed_scaled
);

  localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                s1_valid;
  logic [10:0]         s1_fid;
  logic [10:0]         s1_wid;
  logic [12:0]         s1_angle;
  logic signed [15:0]  s1_speed;
  logic                s1_adv;

  // stage 1 moves on whenever the result register is free or being drained
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_fid   <= frame_id;
      s1_wid   <= wanted_id;
      s1_angle <= encoder_angle;
      s1_speed <= rotor_speed;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame match and motor select
  // ---------------------------------------------------------------------------
  logic [10:0]      offset;
  logic             hit;
  logic [IDX_W-1:0] idx;

  assign offset = s1_fid - mmeu_pkg::BASE_ID;
  assign hit    = (s1_fid == s1_wid) && (s1_fid >= mmeu_pkg::BASE_ID) &&
                  (offset < 11'(MOTORS));
  assign idx    = offset[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Per-motor state
  // ---------------------------------------------------------------------------
  logic        [12:0] prev_angle [MOTORS];
  logic signed [13:0] prev_step  [MOTORS];
  logic        [47:0] turn_total [MOTORS];

  logic signed [13:0] step;
  logic        [47:0] total_next;
  logic signed [10:0] scaled;

  mmeu_step u_step (
    .angle      (s1_angle),
    .prev_angle (prev_angle[idx]),
    .prev_step  (prev_step[idx]),
    .speed      (s1_speed),
    .step       (step)
  );

  // 48-bit wrapping add of the sign-extended step
  assign total_next = turn_total[idx] + {{34{step[13]}}, step};
  assign scaled     = mmeu_pkg::speed_div60(s1_speed);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        prev_angle[i] <= '0;
        prev_step[i]  <= '0;
        turn_total[i] <= '0;
      end
    end else if (s1_adv && hit) begin
      prev_angle[idx] <= s1_angle;
      prev_step[idx]  <= step;
      turn_total[idx] <= total_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register; a rejected frame still yields one all-zero result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      accepted     <= hit;
      motor_num    <= hit ? offset[1:0] : 2'd0;
      total_ticks  <= hit ? $signed(total_next) : 48'sd0;
      speed_scaled <= hit ? scaled : 11'sd0;
    end
  end

`ifndef NO_ASSERTIONS
  // a rejected result carries zeros in every payload field
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |->
      (motor_num == 2'd0 && total_ticks == 48'sd0 && speed_scaled == 11'sd0))
    else $error("rejected result has nonzero payload");

  // input side stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without back-pressure");

  // an accepted result reports the total just written for its motor
  a_total_written: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && hit) |=> (accepted && total_ticks == $signed(turn_total[$past(idx)])))
    else $error("result total differs from stored total");

  // a held stage-1 item is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stage 1 item dropped while stalled");
`endif

endmodule
`default_nettype wire
